[rtl/bmwd_pkg.sv]
// Shared types, widths and register codes of the baseline-corrected MWD pulse shaper.
package bmwd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 16;
  localparam int D_W      = SAMPLE_W + 1;
  localparam int DIFF_W   = D_W + 1;
  localparam int WSUM_W   = 28;
  localparam int OUT_W    = 29;
  localparam int TAU_W    = 24;
  localparam int TAU_FRAC = 24;
  localparam int LOG2_W   = 3;
  localparam int WLEN_W   = 11;
  localparam int TGT_W    = 8;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  typedef enum logic [1:0] {
    REG_POLARITY   = 2'd0,
    REG_BASE_LOG2  = 2'd1,
    REG_WINDOW_LEN = 2'd2,
    REG_INV_TAU    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                positive_polarity;
    logic [LOG2_W-1:0]   baseline_log2;
    logic [WLEN_W-1:0]   window_len;
    logic [TAU_W-1:0]    inv_tau;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    positive_polarity: 1'b1,
    baseline_log2:     3'd4,
    window_len:        11'd100,
    inv_tau:           24'd16777
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_sample;
    logic                end_of_trace;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] shaped_value;
    logic [IDX_W-1:0]        sample_index;
    logic                    trace_done;
  } out_item_t;

endpackage

[rtl/bmwd_stream_if.sv]
// Valid/ready stream channel with a typed payload.
interface bmwd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bmwd_div.sv]
// Restoring divider that produces one quotient bit per cycle for the baseline average.
module bmwd_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7,
  parameter int QUOT_W     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [QUOT_W-1:0]     quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, div_q};
    take  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[QUOT_W-1:0];

endmodule

[rtl/bmwd_baseline.sv]
// Baseline: buffers and averages the leading samples, releases them in order, then the rest.
module bmwd_baseline
  import bmwd_pkg::*;
#(
  parameter int BASELINE_MAX = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  bmwd_stream_if.sink          in_i,
  bmwd_stream_if.source        smp_o,
  output logic [SAMPLE_W-1:0]  baseline_o
);

  localparam int CNT_W  = $clog2(BASELINE_MAX + 1);
  localparam int BUF_AW = (BASELINE_MAX > 1) ? $clog2(BASELINE_MAX) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(BASELINE_MAX);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_DIV,
    ST_DRAIN,
    ST_RUN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    fill_q;
  logic [CNT_W-1:0]    fill_nx;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_nx;
  logic [SAMPLE_W-1:0] bval_q;
  logic                ended_q;
  logic [CNT_W-1:0]    rd_cnt_q;
  logic [CNT_W-1:0]    iss_cnt_q;
  logic [CNT_W-1:0]    iss_nx;
  logic [SAMPLE_W-1:0] bdat_q;
  logic                bdat_v_q;
  logic [TGT_W-1:0]    tgt_raw;
  logic [TGT_W-1:0]    tgt;
  logic                fill_acc;
  logic                complete;
  logic                iss;
  logic                rd_en;
  logic                run_last;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;

  logic [SAMPLE_W-1:0] bl_mem [BASELINE_MAX];

  always_comb begin
    tgt_raw  = TGT_W'(1) << cfg_i.baseline_log2;
    tgt      = (tgt_raw > TGT_W'(BASELINE_MAX)) ? TGT_W'(BASELINE_MAX) : tgt_raw;
    fill_nx  = fill_q + CNT_W'(1);
    sum_nx   = sum_q + SUM_W'(in_i.data.raw_sample);
    iss_nx   = iss_cnt_q + CNT_W'(1);
    fill_acc = (state_q == ST_FILL) && in_i.valid;
    complete = fill_acc && ((TGT_W'(fill_nx) >= tgt) || in_i.data.end_of_trace);

    in_i.ready = 1'b0;
    smp_o.valid = 1'b0;
    smp_o.data  = in_i.data;
    unique case (state_q)
      ST_FILL: in_i.ready = 1'b1;
      ST_DIV: smp_o.valid = 1'b0;
      ST_DRAIN: begin
        smp_o.valid = bdat_v_q;
        smp_o.data.raw_sample   = bdat_q;
        smp_o.data.end_of_trace = ended_q && (iss_nx == fill_q);
      end
      ST_RUN: begin
        smp_o.valid = in_i.valid;
        in_i.ready  = smp_o.ready;
      end
    endcase

    iss      = (state_q == ST_DRAIN) && smp_o.valid && smp_o.ready;
    rd_en    = (state_q == ST_DRAIN) && (rd_cnt_q < fill_q) && (!bdat_v_q || iss);
    run_last = (state_q == ST_RUN) && in_i.valid && smp_o.ready && in_i.data.end_of_trace;
  end

  bmwd_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (SAMPLE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (complete),
    .dividend_i (sum_nx),
    .divisor_i  (fill_nx),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      fill_q    <= '0;
      sum_q     <= '0;
      bval_q    <= '0;
      ended_q   <= 1'b0;
      rd_cnt_q  <= '0;
      iss_cnt_q <= '0;
      bdat_v_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          if (fill_acc) begin
            sum_q   <= sum_nx;
            fill_q  <= fill_nx;
            ended_q <= in_i.data.end_of_trace;
            if (complete) begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            bval_q    <= div_quot;
            rd_cnt_q  <= '0;
            iss_cnt_q <= '0;
            bdat_v_q  <= 1'b0;
            state_q   <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + CNT_W'(1);
            bdat_v_q <= 1'b1;
          end else if (iss) begin
            bdat_v_q <= 1'b0;
          end
          if (iss) begin
            iss_cnt_q <= iss_nx;
            if (iss_nx == fill_q) begin
              if (ended_q) begin
                sum_q   <= '0;
                fill_q  <= '0;
                bval_q  <= '0;
                ended_q <= 1'b0;
                state_q <= ST_FILL;
              end else begin
                state_q <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (run_last) begin
            sum_q   <= '0;
            fill_q  <= '0;
            bval_q  <= '0;
            ended_q <= 1'b0;
            state_q <= ST_FILL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_acc) begin
      bl_mem[fill_q[BUF_AW-1:0]] <= in_i.data.raw_sample;
    end
    if (rd_en) begin
      bdat_q <= bl_mem[rd_cnt_q[BUF_AW-1:0]];
    end
  end

  assign baseline_o = bval_q;

endmodule

[rtl/bmwd_shaper.sv]
// Deconvolution pipeline around the corrected-sample delay line memory.
module bmwd_shaper
  import bmwd_pkg::*;
#(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic [SAMPLE_W-1:0] baseline_i,
  bmwd_stream_if.sink         smp_i,
  bmwd_stream_if.source       out_o
);

  localparam int WA_W   = $clog2(WINDOW_MAX);
  localparam int WMW    = $clog2(WINDOW_MAX + 1);
  localparam int M_W    = (WMW > WLEN_W) ? WMW : WLEN_W;
  localparam int PROD_W = WSUM_W + TAU_W + 1;

  logic [D_W-1:0] dl_mem [WINDOW_MAX];

  logic [WA_W-1:0]  ptr_q;
  logic [WA_W-1:0]  ra;
  logic [IDX_W-1:0] pos_q;
  logic [WSUM_W-1:0] wsum_q;
  logic [WSUM_W-1:0] wnew;

  logic v1_q, v2_q, v3_q, vo_q;
  logic adv_o, rdy1, rdy2, rdy3, mv1, mv2, mv3, issue;

  logic [M_W-1:0]   wl;
  logic [M_W-1:0]   m;
  logic [M_W:0]     pe;
  logic [M_W:0]     me;
  logic [M_W:0]     rsub;
  logic             ge_c;
  logic [D_W-1:0]   s_ext;
  logic [D_W-1:0]   b_ext;
  logic signed [D_W-1:0] d_c;

  logic signed [D_W-1:0] d1_q;
  logic signed [D_W-1:0] old_q;
  logic signed [D_W-1:0] old_m;
  logic                  last1_q;
  logic                  ge1_q;
  logic [IDX_W-1:0]      idx1_q;

  logic signed [DIFF_W-1:0] diff_c;
  logic signed [DIFF_W-1:0] diff2_q;
  logic signed [WSUM_W-1:0] w2_q;
  logic                     last2_q;
  logic                     ge2_q;
  logic [IDX_W-1:0]         idx2_q;

  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod3_q;
  logic signed [DIFF_W-1:0] diff3_q;
  logic                     last3_q;
  logic                     ge3_q;
  logic [IDX_W-1:0]         idx3_q;

  logic signed [WSUM_W-1:0] scaled_c;
  logic signed [OUT_W-1:0]  shaped_c;
  out_item_t                out_q;

  assign adv_o = !vo_q || out_o.ready;
  assign rdy3  = !v3_q || adv_o;
  assign mv3   = v3_q && adv_o;
  assign rdy2  = !v2_q || rdy3;
  assign mv2   = v2_q && rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign mv1   = v1_q && rdy2;
  assign issue = smp_i.valid && rdy1;
  assign smp_i.ready = rdy1;

  always_comb begin
    s_ext = {1'b0, smp_i.data.raw_sample};
    b_ext = {1'b0, baseline_i};
    d_c   = cfg_i.positive_polarity ? (s_ext - b_ext) : (b_ext - s_ext);

    wl = M_W'(cfg_i.window_len);
    if (wl == '0) begin
      m = M_W'(1);
    end else if (wl > M_W'(WINDOW_MAX)) begin
      m = M_W'(WINDOW_MAX);
    end else begin
      m = wl;
    end
    ge_c = pos_q >= IDX_W'(m);

    pe   = (M_W + 1)'(ptr_q);
    me   = (M_W + 1)'(m);
    rsub = (pe >= me) ? (pe - me) : (pe + (M_W + 1)'(WINDOW_MAX) - me);
    ra   = rsub[WA_W-1:0];

    old_m  = ge1_q ? old_q : '0;
    wnew   = wsum_q + WSUM_W'(d1_q) - WSUM_W'(old_m);
    diff_c = DIFF_W'(d1_q) - DIFF_W'(old_m);

    prod_c = w2_q * $signed({1'b0, cfg_i.inv_tau});

    scaled_c = prod3_q[TAU_FRAC+WSUM_W-1:TAU_FRAC];
    shaped_c = OUT_W'(diff3_q) + OUT_W'(scaled_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
      ptr_q  <= '0;
      pos_q  <= '0;
      wsum_q <= '0;
    end else begin
      if (adv_o) begin
        vo_q <= v3_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy1) begin
        v1_q <= issue;
      end
      if (issue) begin
        if (smp_i.data.end_of_trace) begin
          ptr_q <= '0;
          pos_q <= '0;
        end else begin
          ptr_q <= (ptr_q == WA_W'(WINDOW_MAX - 1)) ? '0 : ptr_q + WA_W'(1);
          pos_q <= (pos_q == '1) ? pos_q : pos_q + IDX_W'(1);
        end
      end
      if (mv1) begin
        wsum_q <= last1_q ? '0 : wnew;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      old_q          <= dl_mem[ra];
      dl_mem[ptr_q]  <= d_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      d1_q    <= d_c;
      last1_q <= smp_i.data.end_of_trace;
      ge1_q   <= ge_c;
      idx1_q  <= pos_q;
    end
    if (mv1) begin
      diff2_q <= diff_c;
      w2_q    <= wnew;
      last2_q <= last1_q;
      ge2_q   <= ge1_q;
      idx2_q  <= idx1_q;
    end
    if (mv2) begin
      prod3_q <= prod_c;
      diff3_q <= diff2_q;
      last3_q <= last2_q;
      ge3_q   <= ge2_q;
      idx3_q  <= idx2_q;
    end
    if (mv3) begin
      out_q.shaped_value <= ge3_q ? shaped_c : '0;
      out_q.sample_index <= idx3_q;
      out_q.trace_done   <= last3_q;
    end
  end

  assign out_o.valid = vo_q;
  assign out_o.data  = out_q;

endmodule

[rtl/baseline_mwd_pulse_shaper.sv]
// Top level of the baseline-corrected moving window deconvolution pulse shaper.
//
// Raw samples arrive on in_i as transactions carrying raw_sample and end_of_trace.
// Shaped results leave on out_o, one transaction per sample, in sample order.
// Registers (polarity, baseline count, window length, decay reciprocal) sit on the
// APB port at byte addresses 0, 4, 8 and 12; the user must write them between traces,
// as the block itself does not enforce it. The first 2^k samples of a trace (at most
// BASELINE_MAX) are stored in the baseline buffer at one per cycle. When the last of
// them (or the trace end) arrives, the input stalls while the bit-serial divider
// forms the average and while the buffered samples are replayed into the shaping
// pipeline at one per cycle as long as the pipeline accepts them. After that one
// sample is taken per cycle while the pipeline is not stalled, with one read and one
// write of the delay line memory per cycle. A sample's result moves through the d1_q,
// w2_q and prod3_q stage registers into the output register. When out_o is not ready
// the pipeline holds its contents and the input stalls only once every stage is full.
// Reset restores the register defaults and starts a new trace; buffer and delay line contents are not cleared.
module baseline_mwd_pulse_shaper
  import bmwd_pkg::*;
#(
  parameter int WINDOW_MAX   = 1024,
  parameter int BASELINE_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  bmwd_stream_if.sink       in_i,
  bmwd_stream_if.source     out_o
);

  cfg_t                cfg_q;
  cfg_reg_e            reg_sel;
  logic                cfg_wr;
  logic [SAMPLE_W-1:0] baseline;

  bmwd_stream_if #(.T(in_item_t)) smp_if ();

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POLARITY:   cfg_q.positive_polarity <= pwdata[0];
        REG_BASE_LOG2:  cfg_q.baseline_log2     <= pwdata[LOG2_W-1:0];
        REG_WINDOW_LEN: cfg_q.window_len        <= pwdata[WLEN_W-1:0];
        REG_INV_TAU:    cfg_q.inv_tau           <= pwdata[TAU_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POLARITY:   prdata = CFG_DW'(cfg_q.positive_polarity);
      REG_BASE_LOG2:  prdata = CFG_DW'(cfg_q.baseline_log2);
      REG_WINDOW_LEN: prdata = CFG_DW'(cfg_q.window_len);
      REG_INV_TAU:    prdata = CFG_DW'(cfg_q.inv_tau);
    endcase
  end

  bmwd_baseline #(
    .BASELINE_MAX (BASELINE_MAX)
  ) u_baseline (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .smp_o      (smp_if.source),
    .baseline_o (baseline)
  );

  bmwd_shaper #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_shaper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .baseline_i (baseline),
    .smp_i      (smp_if.sink),
    .out_o      (out_o)
  );

endmodule

[tb/sv/mwd_shape_check.sv]
`timescale 1ns / 100ps
// Checker that watches the register port and both channels, predicts shaped results and compares them.
module mwd_shape_check
  import bmwd_pkg::*;
#(
  parameter int WINDOW_MAX   = 1024,
  parameter int BASELINE_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [CFG_AW-1:0] paddr_i,
  input  logic [CFG_DW-1:0] pwdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);

  cfg_t                    cfg;
  logic [SAMPLE_W-1:0]     base_buf [BASELINE_MAX];
  logic [21:0]             base_sum;
  logic [SAMPLE_W-1:0]     base_val;
  logic                    base_ready;
  logic signed [D_W-1:0]   dline [WINDOW_MAX];
  logic [WSUM_W-1:0]       wsum;
  logic [IDX_W-1:0]        pos;
  int                      fill;
  int                      wr_ptr;
  out_item_t               shaped_q [$];
  int unsigned             mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_trace();
    base_sum   = '0;
    base_val   = '0;
    base_ready = 1'b0;
    wsum       = '0;
    pos        = '0;
    fill       = 0;
    wr_ptr     = 0;
  endfunction

  task automatic shape_sample(input logic [SAMPLE_W-1:0] s, input logic done);
    int        dv;
    int        old_d;
    int        m;
    longint    w;
    longint    shaped;
    out_item_t r;
    dv = cfg.positive_polarity ? int'(s) - int'(base_val) : int'(base_val) - int'(s);
    m  = int'(cfg.window_len);
    if (m < 1) m = 1;
    if (m > WINDOW_MAX) m = WINDOW_MAX;
    old_d = 0;
    if (int'(pos) >= m) old_d = dline[(wr_ptr + WINDOW_MAX - m) % WINDOW_MAX];
    dline[wr_ptr] = dv[D_W-1:0];
    wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
    w = longint'($signed(wsum)) + longint'(dv) - longint'(old_d);
    wsum = w[WSUM_W-1:0];
    shaped = 0;
    if (int'(pos) >= m) begin
      shaped = longint'(dv) - longint'(old_d)
             + ((longint'($signed(wsum)) * longint'(cfg.inv_tau)) >>> TAU_FRAC);
    end
    r.shaped_value = shaped[OUT_W-1:0];
    r.sample_index = pos;
    r.trace_done   = done;
    shaped_q.push_back(r);
    if (pos != {IDX_W{1'b1}}) pos++;
  endtask

  task automatic take_raw_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    int tgt;
    if (!base_ready) begin
      tgt = 1 << cfg.baseline_log2;
      if (tgt > BASELINE_MAX) tgt = BASELINE_MAX;
      if (fill >= BASELINE_MAX) fill = BASELINE_MAX - 1;
      base_buf[fill] = s;
      base_sum += 22'(s);
      fill++;
      if (fill >= tgt || last) begin
        base_val   = SAMPLE_W'(int'(base_sum) / fill);
        base_ready = 1'b1;
        for (int k = 0; k < fill; k++) begin
          shape_sample(base_buf[k], last && (k + 1 == fill));
        end
      end
    end else begin
      shape_sample(s, last);
    end
    if (last) clear_trace();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg = CFG_RST;
      clear_trace();
      shaped_q.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[3:2]))
          REG_POLARITY:   cfg.positive_polarity = pwdata_i[0];
          REG_BASE_LOG2:  cfg.baseline_log2     = pwdata_i[LOG2_W-1:0];
          REG_WINDOW_LEN: cfg.window_len        = pwdata_i[WLEN_W-1:0];
          REG_INV_TAU:    cfg.inv_tau           = pwdata_i[TAU_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        take_raw_sample(in_data_i.raw_sample, in_data_i.end_of_trace);
      end
      if (out_valid_i && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          report_mismatch($sformatf("result with no expectation, index %0d",
                                    out_data_i.sample_index));
        end else begin
          want = shaped_q.pop_front();
          if (out_data_i.shaped_value !== want.shaped_value) begin
            report_mismatch($sformatf("shaped_value at index %0d: got %0d, want %0d",
                                      want.sample_index, out_data_i.shaped_value,
                                      want.shaped_value));
          end
          if (out_data_i.sample_index !== want.sample_index) begin
            report_mismatch($sformatf("sample_index: got %0d, want %0d",
                                      out_data_i.sample_index, want.sample_index));
          end
          if (out_data_i.trace_done !== want.trace_done) begin
            report_mismatch($sformatf("trace_done at index %0d: got %0b, want %0b",
                                      want.sample_index, out_data_i.trace_done,
                                      want.trace_done));
          end
        end
      end
      pending_o <= shaped_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top that drives reset, register writes and sample traces and reports the verdict.
module tb_top;
  import bmwd_pkg::*;

  localparam int WINDOW_MAX   = 1024;
  localparam int BASELINE_MAX = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int unsigned       pending;
  int unsigned       errors;
  int unsigned       send_idle_pct = 19;
  int unsigned       recv_idle_pct = 63;
  logic              hold_off_req  = 1'b0;

  bmwd_stream_if #(.T(in_item_t))  in_if ();
  bmwd_stream_if #(.T(out_item_t)) out_if ();

  baseline_mwd_pulse_shaper #(
    .WINDOW_MAX  (WINDOW_MAX),
    .BASELINE_MAX(BASELINE_MAX)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  mwd_shape_check #(
    .WINDOW_MAX  (WINDOW_MAX),
    .BASELINE_MAX(BASELINE_MAX)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .in_data_i  (in_if.data),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_i (out_if.data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DW-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic pol, input logic [LOG2_W-1:0] k,
                            input logic [WLEN_W-1:0] m, input logic [TAU_W-1:0] tau);
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    write_reg(REG_POLARITY, CFG_DW'(pol));
    write_reg(REG_BASE_LOG2, CFG_DW'(k));
    write_reg(REG_WINDOW_LEN, CFG_DW'(m));
    write_reg(REG_INV_TAU, CFG_DW'(tau));
  endtask

  task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{raw_sample: s, end_of_trace: last};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int level);
    int v;
    if ($urandom_range(3) == 0) return SAMPLE_W'($urandom);
    v = level + int'($urandom_range(255)) - 128;
    if ($urandom_range(15) == 0) v += int'($urandom_range(20000));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_trace(input int len, input int level);
    for (int i = 0; i < len; i++) begin
      send_item(pick_sample(level), i == len - 1);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic random_group(input int n_set);
    logic [LOG2_W-1:0] k;
    logic [WLEN_W-1:0] m;
    int                tgt;
    int                mm;
    int                cap;
    int                len;
    int                n_tr;
    for (int s = 0; s < n_set; s++) begin
      k = ($urandom_range(9) == 0) ? 3'd7 : LOG2_W'($urandom_range(6));
      m = ($urandom_range(4) == 0) ? WLEN_W'($urandom_range(2047))
                                   : WLEN_W'($urandom_range(24, 1));
      set_config(1'($urandom_range(1)), k, m,
                 $urandom_range(1) ? TAU_W'($urandom) : TAU_W'($urandom_range(65536)));
      tgt = 1 << k;
      if (tgt > BASELINE_MAX) tgt = BASELINE_MAX;
      mm = (m == 0) ? 1 : ((m > WINDOW_MAX) ? WINDOW_MAX : int'(m));
      cap = tgt + mm + 16;
      if (cap > 40) cap = 40;
      n_tr = $urandom_range(2, 1);
      for (int t = 0; t < n_tr; t++) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(tgt, 1) : $urandom_range(cap, tgt);
        send_trace(len, $urandom_range(65535));
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Traces shorter than the baseline count under the reset settings.
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b1);
    in_if.valid <= 1'b0;

    set_config(1'b0, 3'd0, 11'd1, 24'hFFFFFF);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b1);
    in_if.valid <= 1'b0;

    set_config(1'b1, 3'd1, 11'd2, 24'h800000);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFE, 1'b1);
    in_if.valid <= 1'b0;

    random_group(2);

    set_config(1'b1, 3'd2, 11'd8, 24'h100000);
    hold_off_req = 1'b1;
    send_trace(40, 20000);

    send_idle_pct = 63;
    recv_idle_pct = 19;
    random_group(2);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(1'b0, 3'd7, 11'd2047, 24'hFFFFFF);
    send_trace(70, 30000);
    set_config(1'b1, 3'd0, 11'd0, TAU_W'($urandom));
    send_trace(16, 10000);

    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
